// File: hdl/huff_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huff_pkg
// Fixed field widths and limits of the Huffman code builder.
// ----------------------------------------------------------------------------
package huff_pkg;

	localparam int SYM_W      = 8;
	localparam int WEIGHT_IN_W = 16;
	localparam int CODE_W     = 31;
	localparam int LEN_W      = 5;
	localparam int PATH_W     = 27;

	localparam int unsigned CODE_MAX_LEN = 31;
	localparam logic [PATH_W-1:0] PATH_MAX = {PATH_W{1'b1}};

endpackage

// File: hdl/huff_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huff_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module huff_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hdl/huffman_code_builder.sv
`timescale 1ns / 1ps
// Load: one leaf per cycle while busy is low; the closing leaf (last) starts the build.
// Build: each merge creating node k scans nodes 0 to k-1 (one RAM read per scanned node).
// Codes: each stored leaf walks up the parent RAM; one strobe per stored leaf, in load order.
// Results cannot be stalled.
// Reset (arst_n low) clears control, leaf count, drop flag and parent flags; RAMs keep contents.
// ----------------------------------------------------------------------------
// huffman_code_builder
// Builds Huffman codes for a loaded leaf set with one shared min-scan unit.
// ----------------------------------------------------------------------------
module huffman_code_builder #(
	parameter int MAX_LEAVES  = 32,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [huff_pkg::SYM_W-1:0]      symbol,
	input  logic [huff_pkg::WEIGHT_IN_W-1:0] weight,
	input  logic                            last,
	output logic                            res_strobe,
	output logic [huff_pkg::SYM_W-1:0]      leaf_symbol,
	output logic [huff_pkg::CODE_W-1:0]     code_bits,
	output logic [huff_pkg::LEN_W-1:0]      code_length,
	output logic [huff_pkg::PATH_W-1:0]     path_total,
	output logic                            dropped,
	output logic                            final_res
);

	// node and counter widths
	localparam int NC   = 2 * MAX_LEAVES - 1;
	localparam int NIW  = $clog2(NC);
	localparam int SAW  = $clog2(MAX_LEAVES);
	localparam int CW   = $clog2(MAX_LEAVES + 1);
	localparam int LW   = (WEIGHT_BITS < huff_pkg::WEIGHT_IN_W) ? WEIGHT_BITS
		: huff_pkg::WEIGHT_IN_W;
	localparam int NW   = LW + $clog2(MAX_LEAVES);
	localparam int LENW = $clog2(MAX_LEAVES) + 1;
	localparam int SUMW = ((NW > huff_pkg::PATH_W) ? NW : huff_pkg::PATH_W) + 1;

	typedef enum logic [2:0] {
		IDLE, SCAN, SCAN_END, MERGE, MERGE2, WSTART, WSTEP, WUP
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     cnt_q;
	logic              ovf_q;
	logic [NIW-1:0]    k_q;
	logic [NIW-1:0]    scan_q;
	logic              vld_s1;
	logic [NIW-1:0]    idx_s1;
	logic [NIW-1:0]    m1_q, m2_q;
	logic              m1v_q, m2v_q;
	logic [NW-1:0]     w1_q, w2_q;
	logic [huff_pkg::PATH_W-1:0] path_q;
	logic [NC-1:0]     haspar_q;
	logic [SAW-1:0]    leaf_q;
	logic [NIW-1:0]    child_q;
	logic [LENW-1:0]   len_q;
	logic [huff_pkg::CODE_W-1:0] code_q;
	logic              emit_q;

	logic              accept;
	logic              store;
	logic [CW-1:0]     n_next;
	logic [NIW:0]      k_lim;
	logic [NW-1:0]     sum;
	logic [SUMW-1:0]   acc;
	logic [31:0]       len32;
	logic              is_final;

	// RAM ports
	logic                  sym_we, sym_re;
	logic [SAW-1:0]        sym_waddr, sym_raddr;
	logic [huff_pkg::SYM_W-1:0] sym_rdata;
	logic                  wt_we, wt_re;
	logic [NIW-1:0]        wt_waddr, wt_raddr;
	logic [NW-1:0]         wt_wdata, wt_rdata;
	logic                  par_we, par_re;
	logic [NIW-1:0]        par_waddr, par_raddr;
	logic [NIW:0]          par_wdata, par_rdata;

	assign busy     = (state_q != IDLE);
	assign accept   = start && !busy;
	assign store    = accept && (cnt_q < CW'(MAX_LEAVES));
	assign n_next   = store ? cnt_q + CW'(1) : cnt_q;
	// last merge creates node 2n - 2
	assign k_lim    = ((NIW+1)'(cnt_q) << 1) - (NIW+1)'(1);
	assign sum      = w1_q + w2_q;
	assign acc      = SUMW'(path_q) + SUMW'(sum);
	assign len32    = 32'(len_q);
	assign is_final = (CW'(leaf_q) + CW'(1)) == cnt_q;

	always_comb begin
		sym_we    = store;
		sym_waddr = cnt_q[SAW-1:0];
		sym_re    = (state_q == WSTART);
		sym_raddr = leaf_q;

		wt_we     = store || (state_q == MERGE);
		wt_waddr  = (state_q == MERGE) ? k_q : NIW'(cnt_q);
		wt_wdata  = (state_q == MERGE) ? sum : NW'(weight[LW-1:0]);
		wt_re     = (state_q == SCAN);
		wt_raddr  = scan_q;

		par_we    = (state_q == MERGE) || (state_q == MERGE2);
		par_waddr = (state_q == MERGE) ? m1_q : m2_q;
		// low bit marks a left child
		par_wdata = {k_q, (state_q == MERGE)};
		par_re    = (state_q == WSTEP) && haspar_q[child_q];
		par_raddr = child_q;
	end

	huff_ram #(.WIDTH(huff_pkg::SYM_W), .DEPTH(MAX_LEAVES)) u_sym_ram (
		.clk(clk), .we(sym_we), .waddr(sym_waddr), .wdata(symbol),
		.re(sym_re), .raddr(sym_raddr), .rdata(sym_rdata)
	);

	huff_ram #(.WIDTH(NW), .DEPTH(NC)) u_wt_ram (
		.clk(clk), .we(wt_we), .waddr(wt_waddr), .wdata(wt_wdata),
		.re(wt_re), .raddr(wt_raddr), .rdata(wt_rdata)
	);

	huff_ram #(.WIDTH(NIW + 1), .DEPTH(NC)) u_par_ram (
		.clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
		.re(par_re), .raddr(par_raddr), .rdata(par_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			cnt_q      <= '0;
			ovf_q      <= 1'b0;
			haspar_q   <= '0;
			vld_s1     <= 1'b0;
			emit_q     <= 1'b0;
			res_strobe <= 1'b0;
		end else begin
			vld_s1     <= 1'b0;
			res_strobe <= 1'b0;

			// shared min unit: keep the two lightest parentless nodes, lower index on a tie
			if (vld_s1 && !haspar_q[idx_s1]) begin
				if (!m1v_q || (wt_rdata < w1_q)) begin
					m2_q  <= m1_q;
					w2_q  <= w1_q;
					m2v_q <= m1v_q;
					m1_q  <= idx_s1;
					w1_q  <= wt_rdata;
					m1v_q <= 1'b1;
				end else if (!m2v_q || (wt_rdata < w2_q)) begin
					m2_q  <= idx_s1;
					w2_q  <= wt_rdata;
					m2v_q <= 1'b1;
				end
			end

			unique case (state_q)
				IDLE: begin
					if (accept) begin
						cnt_q <= n_next;
						if (!store) begin
							ovf_q <= 1'b1;
						end
						if (last) begin
							path_q <= '0;
							leaf_q <= '0;
							k_q    <= NIW'(n_next);
							scan_q <= '0;
							m1v_q  <= 1'b0;
							m2v_q  <= 1'b0;
							// a single leaf needs no merge
							state_q <= (n_next == CW'(1)) ? WSTART : SCAN;
						end
					end
				end
				SCAN: begin
					vld_s1 <= 1'b1;
					idx_s1 <= scan_q;
					if (scan_q == k_q - NIW'(1)) begin
						state_q <= SCAN_END;
					end else begin
						scan_q <= scan_q + NIW'(1);
					end
				end
				SCAN_END: begin
					state_q <= MERGE;
				end
				MERGE: begin
					haspar_q[m1_q] <= 1'b1;
					haspar_q[m2_q] <= 1'b1;
					// weighted path length is the sum of all merged weights
					if (acc > SUMW'(huff_pkg::PATH_MAX)) begin
						path_q <= huff_pkg::PATH_MAX;
					end else begin
						path_q <= acc[huff_pkg::PATH_W-1:0];
					end
					state_q <= MERGE2;
				end
				MERGE2: begin
					k_q    <= k_q + NIW'(1);
					scan_q <= '0;
					m1v_q  <= 1'b0;
					m2v_q  <= 1'b0;
					state_q <= ((NIW+1)'(k_q) + (NIW+1)'(1) == k_lim) ? WSTART : SCAN;
				end
				WSTART: begin
					child_q <= NIW'(leaf_q);
					len_q   <= '0;
					code_q  <= '0;
					emit_q  <= 1'b0;
					state_q <= WSTEP;
				end
				WSTEP: begin
					if (haspar_q[child_q]) begin
						state_q <= WUP;
					end else begin
						// root reached: present the result
						res_strobe  <= 1'b1;
						leaf_symbol <= sym_rdata;
						code_bits   <= code_q;
						code_length <= (len_q == '0) ? huff_pkg::LEN_W'(1)
							: ((len32 > huff_pkg::CODE_MAX_LEN)
								? huff_pkg::LEN_W'(huff_pkg::CODE_MAX_LEN)
								: huff_pkg::LEN_W'(len_q));
						path_total  <= path_q;
						dropped     <= ovf_q;
						final_res   <= is_final;
						emit_q      <= 1'b1;
						if (is_final) begin
							cnt_q    <= '0;
							ovf_q    <= 1'b0;
							haspar_q <= '0;
							state_q  <= IDLE;
						end else begin
							leaf_q  <= leaf_q + SAW'(1);
							state_q <= WSTART;
						end
					end
				end
				WUP: begin
					child_q <= par_rdata[NIW:1];
					if ((len32 < huff_pkg::CODE_MAX_LEN) && !par_rdata[0]) begin
						code_q[huff_pkg::LEN_W'(len_q)] <= 1'b1;
					end
					len_q   <= len_q + LENW'(1);
					state_q <= WSTEP;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// the final result of a run is never followed by another in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe && final_res |=> !res_strobe)
		else $error("result after final result");

	// a closing transaction always starts a build
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last |=> busy)
		else $error("build not started");

	// every reported code has at least one bit
	assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe |-> code_length != '0)
		else $error("zero code length");

	// a result strobe is always the one marked by the emit step
	assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe |-> emit_q)
		else $error("stray result strobe");
`endif

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Huffman code builder. Leaf sets are loaded one
// transaction at a time; an in-bench tree builder works out the code of every
// leaf, and each strobed result is compared field by field with the oldest
// outstanding code. Directed sets cover single leaves, ties, weight and symbol
// extremes, skewed trees and capacity overflow; random sets follow.
// ----------------------------------------------------------------------------
module tb;

	localparam int LEAF_CAP  = 32;
	localparam int NODE_SLOTS = 2 * LEAF_CAP - 1;
	localparam int STALL_LIMIT = 20000;   // cycles with no transaction and no strobe
	localparam int TAIL_CYCLES = 200;     // settle time after the last code
	localparam int RANDOM_ITEMS = 300;

	// weight shapes for generated sets
	typedef enum int {W_FULL, W_TIES, W_BYTE, W_EDGE} wshape_t;

	typedef struct packed {
		logic [huff_pkg::SYM_W-1:0]  sym;
		logic [huff_pkg::CODE_W-1:0] code;
		logic [huff_pkg::LEN_W-1:0]  len;
		logic [huff_pkg::PATH_W-1:0] path;
		logic              drop;
		logic              fin;
	} leaf_code_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [huff_pkg::SYM_W-1:0] symbol = '0;
	logic [huff_pkg::WEIGHT_IN_W-1:0] weight = '0;
	logic last = 1'b0;
	logic res_strobe;
	logic [huff_pkg::SYM_W-1:0] leaf_symbol;
	logic [huff_pkg::CODE_W-1:0] code_bits;
	logic [huff_pkg::LEN_W-1:0] code_length;
	logic [huff_pkg::PATH_W-1:0] path_total;
	logic dropped;
	logic final_res;

	// bench copy of the tree state
	logic [huff_pkg::SYM_W-1:0] held_sym [LEAF_CAP];
	logic [63:0]      node_w   [NODE_SLOTS];
	int               node_par [NODE_SLOTS];
	bit               node_left[NODE_SLOTS];
	int               held_count;
	bit               held_drop;

	leaf_code_t pending_codes[$];
	int  errors;
	int  items_sent;
	int  codes_seen;
	int  sets_built;
	int  idle_pct;
	int  quiet_cycles;

	always #1 clk = ~clk;

	huffman_code_builder DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.symbol     (symbol),
		.weight     (weight),
		.last       (last),
		.res_strobe (res_strobe),
		.leaf_symbol(leaf_symbol),
		.code_bits  (code_bits),
		.code_length(code_length),
		.path_total (path_total),
		.dropped    (dropped),
		.final_res  (final_res)
	);

	// Lightest parentless node below limit, skipping one; ties to the lower index.
	function automatic int lightest(int limit, int skip);
		int best;
		best = NODE_SLOTS;
		for (int i = 0; i < limit; i++) begin
			if (i == skip || node_par[i] != 0) continue;
			if (best == NODE_SLOTS || node_w[i] < node_w[best]) best = i;
		end
		return best;
	endfunction

	// Absorb one accepted leaf; on the closing leaf build the tree and queue the codes.
	function automatic void absorb_leaf(logic [huff_pkg::SYM_W-1:0] s,
		logic [huff_pkg::WEIGHT_IN_W-1:0] w, logic l);
		int n, a, b, node, depth;
		logic [31:0] code;
		logic [63:0] path;
		leaf_code_t c;
		if (held_count < LEAF_CAP) begin
			held_sym[held_count] = s;
			node_w[held_count] = 64'(w);
			held_count++;
		end else begin
			held_drop = 1'b1;
		end
		if (!l) return;
		n = held_count;
		for (int i = 0; i < NODE_SLOTS; i++) begin
			node_par[i] = 0;
			node_left[i] = 1'b0;
		end
		for (int k = n; k < 2 * n - 1 && k < NODE_SLOTS; k++) begin
			a = lightest(k, NODE_SLOTS);
			b = lightest(k, a);
			if (a >= NODE_SLOTS || b >= NODE_SLOTS) break;
			node_par[a] = k;
			node_par[b] = k;
			node_left[a] = 1'b1;
			node_left[b] = 1'b0;
			node_w[k] = node_w[a] + node_w[b];
		end
		// walk each leaf up to the root; the path sum is known only at the end
		path = 0;
		for (int i = 0; i < n; i++) begin
			node = i;
			depth = 0;
			code = '0;
			while (node_par[node] != 0 && depth < NODE_SLOTS) begin
				if (depth < huff_pkg::CODE_MAX_LEN && !node_left[node]) code[depth] = 1'b1;
				depth++;
				node = node_par[node];
			end
			path += node_w[i] * 64'(depth);
			if (path > 64'(huff_pkg::PATH_MAX)) path = 64'(huff_pkg::PATH_MAX);
			c.sym  = held_sym[i];
			c.code = code[huff_pkg::CODE_W-1:0];
			c.len  = (depth == 0) ? huff_pkg::LEN_W'(1) :
				(depth > huff_pkg::CODE_MAX_LEN ? huff_pkg::LEN_W'(huff_pkg::CODE_MAX_LEN)
					: huff_pkg::LEN_W'(depth));
			c.path = '0;
			c.drop = held_drop;
			c.fin  = (i + 1 == n);
			pending_codes.insert(pending_codes.size(), c);
		end
		// patch the shared path total into the codes just queued
		for (int i = pending_codes.size() - n; i < pending_codes.size(); i++)
			pending_codes[i].path = path[huff_pkg::PATH_W-1:0];
		held_count = 0;
		held_drop = 1'b0;
		sets_built++;
	endfunction

	// Send one leaf: optional idle gap, then hold start until the block takes it.
	task automatic send_leaf(logic [huff_pkg::SYM_W-1:0] s,
		logic [huff_pkg::WEIGHT_IN_W-1:0] w, logic l);
		if ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(7)) @(negedge clk);
		end
		@(negedge clk);
		start = 1'b1;
		symbol = s;
		weight = w;
		last = l;
		do @(posedge clk); while (busy);
		absorb_leaf(s, w, l);
		items_sent++;
	endtask

	task automatic release_start();
		@(negedge clk);
		start = 1'b0;
		last = 1'b0;
	endtask

	function automatic logic [huff_pkg::WEIGHT_IN_W-1:0] pick_weight(wshape_t shape);
		case (shape)
			W_FULL: return huff_pkg::WEIGHT_IN_W'($urandom);
			W_TIES: return huff_pkg::WEIGHT_IN_W'($urandom_range(3));
			W_BYTE: return huff_pkg::WEIGHT_IN_W'($urandom_range(255));
			default: return $urandom_range(1) ? '1 : '0;
		endcase
	endfunction

	// Load a set of n leaves; leaves past capacity are sent too, and the last closes it.
	task automatic send_set(int n, wshape_t shape);
		for (int i = 0; i < n; i++)
			send_leaf(huff_pkg::SYM_W'($urandom), pick_weight(shape), i == n - 1);
	endtask

	task automatic drain_codes();
		while (pending_codes.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// ---- directed tests ----
	task automatic test_single_leaf();
		send_leaf(8'h5A, 16'd9, 1'b1);          // lone leaf: code 0, length 1, path 0
		send_leaf(8'h00, 16'd0, 1'b1);
	endtask

	task automatic test_pair_and_ties();
		send_leaf(8'h10, 16'd7, 1'b0);
		send_leaf(8'h11, 16'd3, 1'b1);          // lighter one becomes the left child
		for (int i = 0; i < 4; i++)
			send_leaf(huff_pkg::SYM_W'(8'h20 + i), 16'd5, i == 3);   // equal weights
	endtask

	task automatic test_extremes();
		send_leaf(8'h00, 16'hFFFF, 1'b0);
		send_leaf(8'hFF, 16'h0000, 1'b0);
		send_leaf(8'hAA, 16'hFFFF, 1'b0);
		send_leaf(8'h55, 16'h0000, 1'b1);
	endtask

	task automatic test_skewed_tree();
		logic [huff_pkg::WEIGHT_IN_W-1:0] w;
		w = 16'd1;
		for (int i = 0; i < 6; i++) begin
			send_leaf(huff_pkg::SYM_W'(8'h40 + i), w, i == 5);   // doubling weights give a chain
			if (i > 0) w = w << 1;
		end
	endtask

	task automatic test_capacity();
		send_set(LEAF_CAP, W_FULL);                         // exactly full, no drop
		send_set(LEAF_CAP + 1 + $urandom_range(5), W_BYTE); // overflow, last on a dropped leaf
	endtask

	task automatic test_random_sets(int target);
		int n, r, stop_at;
		stop_at = items_sent + target;
		while (items_sent < stop_at) begin
			r = $urandom_range(99);
			if (r < 80) n = $urandom_range(1, 12);
			else if (r < 95) n = $urandom_range(13, LEAF_CAP);
			else n = $urandom_range(LEAF_CAP + 1, LEAF_CAP + 8);
			send_set(n, wshape_t'($urandom_range(3)));
		end
	endtask

	// Check every strobed code against the oldest queued one.
	task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		leaf_code_t c;
		if (arst_n && res_strobe) begin
			codes_seen++;
			if (pending_codes.size() == 0) begin
				$display("%0t ns: unexpected code, expected none, got symbol %0h", $time,
					leaf_symbol);
				errors++;
			end else begin
				c = pending_codes.pop_front();
				compare_field("leaf_symbol", c.sym, leaf_symbol);
				compare_field("code_bits", c.code, code_bits);
				compare_field("code_length", c.len, code_length);
				compare_field("path_total", c.path, path_total);
				compare_field("dropped", c.drop, dropped);
				compare_field("final_res", c.fin, final_res);
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((start && !busy) || res_strobe || !arst_n) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		errors = 0;
		items_sent = 0;
		codes_seen = 0;
		sets_built = 0;
		quiet_cycles = 0;
		held_count = 0;
		held_drop = 1'b0;
		idle_pct = 24;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_single_leaf();
		test_pair_and_ties();
		test_extremes();
		test_skewed_tree();
		test_capacity();
		test_random_sets(RANDOM_ITEMS / 3);
		idle_pct = 72;
		test_random_sets(RANDOM_ITEMS / 3);
		idle_pct = 0;
		test_random_sets(RANDOM_ITEMS / 3);
		release_start();
		drain_codes();

		$display("Loaded %0d leaves in %0d sets, checked %0d codes.", items_sent, sets_built,
			codes_seen);
		$display("Covered lone leaves, ties, extreme weights, skewed trees and overflow.");
		if (errors == 0 && pending_codes.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// File: filelist.f
hdl/huff_pkg.sv
hdl/huff_ram.sv
hdl/huffman_code_builder.sv
test/tb.sv
